// File: hdl/mtc_pkg.sv
// Shared types and constants of the media type classifier.
package mtc_pkg;

   // Only the first STORE_DEPTH characters can ever take part in a comparison:
   // the longest string looked for is "application/x-font-woff2".
   localparam int STORE_DEPTH = 24;
   localparam int STORE_IDX_W = 5;

   // Snapshot length: 0..STORE_DEPTH exact, LEN_OVER for anything longer.
   localparam int LEN_W = 5;
   localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(STORE_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CODE_W = 6;
   localparam logic [CODE_W-1:0] CODE_EMPTY      = 6'd0;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN    = 6'd1;
   localparam int                CODE_TABLE_BASE = 2;
   localparam logic [CODE_W-1:0] CODE_TEXT_ANY   = 6'd2;
   localparam logic [CODE_W-1:0] CODE_JAVASCRIPT = 6'd7;
   localparam logic [CODE_W-1:0] CODE_IMAGE_ANY  = 6'd9;
   localparam logic [CODE_W-1:0] CODE_AUDIO_ANY  = 6'd18;
   localparam logic [CODE_W-1:0] CODE_VIDEO_ANY  = 6'd24;
   localparam logic [CODE_W-1:0] CODE_FONT_ANY   = 6'd30;
   localparam logic [CODE_W-1:0] CODE_FONT_TTF   = 6'd31;
   localparam logic [CODE_W-1:0] CODE_FONT_WOFF  = 6'd32;
   localparam logic [CODE_W-1:0] CODE_FONT_WOFF2 = 6'd33;
   localparam logic [CODE_W-1:0] CODE_APP_ANY    = 6'd34;
   localparam logic [CODE_W-1:0] CODE_APP_XML    = 6'd38;
   localparam logic [CODE_W-1:0] CODE_MAX        = 6'd40;

   typedef logic [7:0] char_type;

   // One finished base, handed from the front end to the classifier.
   typedef struct packed {
      logic                         too_long;
      logic [LEN_W-1:0]             len;
      char_type [STORE_DEPTH-1:0]   chars;
   } snap_type;

   // Queue handshake between the two halves.
   typedef struct packed {
      logic push;
      logic full;
      logic pop;
      logic empty;
   } qctl_type;

endpackage

// File: hdl/mtc_front.sv
// Front end: takes characters, folds case, tracks the trimmed base length.
module mtc_front #(
   parameter int MAX_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_has_char,
   input  logic [7:0]        req_in_char,
   input  logic              req_last,
   input  logic              q_full,
   output logic              q_push,
   output mtc_pkg::snap_type q_data
);
   import mtc_pkg::*;

   localparam int BW = $clog2(MAX_LEN + 1);
   localparam char_type CHAR_SEMI  = 8'h3B;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_TAB   = 8'h09;
   localparam char_type CHAR_UP_A  = 8'h41;
   localparam char_type CHAR_UP_Z  = 8'h5A;
   localparam char_type CASE_BIT   = 8'h20;

   logic [BW-1:0]              raw_ff, raw_in;
   logic [BW-1:0]              base_ff, base_in;
   logic                       long_ff, long_in;
   logic                       semi_ff, semi_in;
   char_type [STORE_DEPTH-1:0] chars_ff, chars_in;

   logic     accept;
   logic     blank;
   char_type folded;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && req_last;

   assign blank  = (req_in_char == CHAR_SPACE) || (req_in_char == CHAR_TAB);
   assign folded = (req_in_char >= CHAR_UP_A && req_in_char <= CHAR_UP_Z) ?
                   (req_in_char | CASE_BIT) : req_in_char;

   always_comb begin
      raw_in   = raw_ff;
      base_in  = base_ff;
      long_in  = long_ff;
      semi_in  = semi_ff;
      chars_in = chars_ff;
      if (accept && req_has_char && !semi_ff) begin
         if (req_in_char == CHAR_SEMI) begin
            semi_in = 1'b1;
         end else if (raw_ff < BW'(MAX_LEN)) begin
            if (raw_ff < BW'(STORE_DEPTH)) begin
               chars_in[raw_ff[STORE_IDX_W-1:0]] = folded;
            end
            raw_in = raw_ff + 1'b1;
            if (!blank) begin
               base_in = raw_ff + 1'b1;
            end
         end else if (!blank) begin
            long_in = 1'b1;
         end
      end
   end

   // snapshot includes the character of the closing word
   always_comb begin
      q_data.chars    = chars_in;
      q_data.too_long = long_in;
      q_data.len      = (base_in > BW'(STORE_DEPTH)) ? LEN_OVER : LEN_W'(base_in);
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (reset || q_push) begin
         raw_ff  <= '0;
         base_ff <= '0;
         long_ff <= 1'b0;
         semi_ff <= 1'b0;
      end else begin
         raw_ff  <= raw_in;
         base_ff <= base_in;
         long_ff <= long_in;
         semi_ff <= semi_in;
      end
   end

endmodule

// File: hdl/mtc_queue.sv
// Short register queue of finished bases between front end and classifier.
module mtc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mtc_pkg::snap_type push_data,
   input  logic              pop,
   output mtc_pkg::snap_type pop_data,
   output logic              full,
   output logic              empty
);
   import mtc_pkg::*;

   snap_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hdl/mtc_classify.sv
// Back end: compares a finished base against the type table, registers the code.
module mtc_classify (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  mtc_pkg::snap_type            q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mtc_pkg::CODE_W-1:0]   rsp_type_code
);
   import mtc_pkg::*;

   localparam int TABLE_SIZE = 39;
   localparam int NAME_W     = 8 * STORE_DEPTH;

   localparam logic [NAME_W-1:0] NAMES [TABLE_SIZE] = '{
      "text/*", "text/calendar", "text/css", "text/csv", "text/html",
      "text/javascript", "text/plain",
      "image/*", "image/avif", "image/bmp", "image/gif", "image/jpeg",
      "image/png", "image/svg+xml", "image/tiff", "image/webp",
      "audio/*", "audio/mpeg", "audio/ogg", "audio/opus", "audio/wav",
      "audio/webm",
      "video/*", "video/mp4", "video/mpeg", "video/ogg", "video/webm",
      "video/x-msvideo",
      "font/*", "font/ttf", "font/woff", "font/woff2",
      "application/*", "application/json", "application/octet-stream",
      "application/pdf", "application/xml", "application/x-tar",
      "application/zip"
   };

   localparam logic [NAME_W-1:0] S_TEXT  = "text/";
   localparam logic [NAME_W-1:0] S_XML   = "xml";
   localparam logic [NAME_W-1:0] S_IMAGE = "image/";
   localparam logic [NAME_W-1:0] S_AUDIO = "audio/";
   localparam logic [NAME_W-1:0] S_VIDEO = "video/";
   localparam logic [NAME_W-1:0] S_FONT  = "font/";
   localparam logic [NAME_W-1:0] S_APP   = "application/";
   localparam logic [NAME_W-1:0] S_X     = "x-";
   localparam logic [NAME_W-1:0] S_JS    = "javascript";
   localparam logic [NAME_W-1:0] S_TTF   = "font-ttf";
   localparam logic [NAME_W-1:0] S_WOFF  = "font-woff";
   localparam logic [NAME_W-1:0] S_WOFF2 = "font-woff2";

   // string literals sit right-justified; count the non-zero bytes
   function automatic int name_len(logic [NAME_W-1:0] s);
      int n;
      n = 0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (s[8*i +: 8] != 8'h00) n++;
      end
      return n;
   endfunction

   function automatic logic bytes_eq(snap_type sn, int off, logic [NAME_W-1:0] s);
      int   n;
      logic ok;
      n  = name_len(s);
      ok = 1'b1;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (i < n && off + i < STORE_DEPTH) begin
            if (sn.chars[STORE_IDX_W'(off + i)] != s[8*(n-1-i) +: 8]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic logic rest_equals(snap_type sn, int off, logic [NAME_W-1:0] s);
      return (int'(sn.len) == off + name_len(s)) && bytes_eq(sn, off, s);
   endfunction

   function automatic logic rest_starts(snap_type sn, int off, logic [NAME_W-1:0] s);
      return (int'(sn.len) >= off + name_len(s)) && bytes_eq(sn, off, s);
   endfunction

   function automatic logic [CODE_W-1:0] classify(snap_type sn);
      logic [CODE_W-1:0] code;
      logic              found;
      int                off;
      code  = CODE_UNKNOWN;
      found = 1'b0;
      off   = name_len(S_APP);
      for (int k = 0; k < TABLE_SIZE; k++) begin
         if (!found && rest_equals(sn, 0, NAMES[k])) begin
            code  = CODE_W'(k + CODE_TABLE_BASE);
            found = 1'b1;
         end
      end
      if (rest_starts(sn, off, S_X)) off = off + name_len(S_X);
      priority if (sn.too_long)                     return CODE_UNKNOWN;
      else if (sn.len == '0)                        return CODE_EMPTY;
      else if (found)                               return code;
      else if (rest_starts(sn, 0, S_TEXT))
         return rest_equals(sn, name_len(S_TEXT), S_XML) ? CODE_APP_XML : CODE_TEXT_ANY;
      else if (rest_starts(sn, 0, S_IMAGE))         return CODE_IMAGE_ANY;
      else if (rest_starts(sn, 0, S_AUDIO))         return CODE_AUDIO_ANY;
      else if (rest_starts(sn, 0, S_VIDEO))         return CODE_VIDEO_ANY;
      else if (rest_starts(sn, 0, S_FONT))          return CODE_FONT_ANY;
      else if (rest_starts(sn, 0, S_APP)) begin
         priority if (rest_equals(sn, off, S_JS))   return CODE_JAVASCRIPT;
         else if (rest_equals(sn, off, S_TTF))      return CODE_FONT_TTF;
         else if (rest_equals(sn, off, S_WOFF))     return CODE_FONT_WOFF;
         else if (rest_equals(sn, off, S_WOFF2))    return CODE_FONT_WOFF2;
         else                                       return CODE_APP_ANY;
      end
      else                                          return CODE_UNKNOWN;
   endfunction

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff, code_in;

   assign q_pop         = q_valid && (!valid_ff || !rsp_stall);
   assign rsp_valid     = valid_ff;
   assign rsp_type_code = code_ff;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         code_in  = classify(q_data);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// File: hdl/mime_type_classifier_top.sv
// Media type classifier: character front end, base queue, table classifier.
// Throughput: one word per cycle while the base queue is not full.
// A closing word's code passes through the queue register, then the
//   classifier output register.
// The two-entry base queue lets the front end run on while a code is stalled.
// Reset (synchronous, active high) clears counters, queue pointers and
//   output valid; the character store and queue payload are not cleared.
module mime_type_classifier_top #(
   parameter int MAX_LEN = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_has_char,
   input  logic [7:0]                 req_in_char,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mtc_pkg::CODE_W-1:0] rsp_type_code
);
   import mtc_pkg::*;

   // front/back handshake around the queue
   qctl_type qctl;
   snap_type push_data;
   snap_type pop_data;

   // Front end: folds case, drops everything after a semicolon and
   // tracks the base length without trailing blanks.  A closing word
   // pushes the finished base; the front stalls only when the queue is full.
   mtc_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_has_char (req_has_char),
      .req_in_char  (req_in_char),
      .req_last     (req_last),
      .q_full       (qctl.full),
      .q_push       (qctl.push),
      .q_data       (push_data)
   );

   mtc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .push_data (push_data),
      .pop       (qctl.pop),
      .pop_data  (pop_data),
      .full      (qctl.full),
      .empty     (qctl.empty)
   );

   // Back end: too-long, empty, exact table match, then category fallbacks.
   mtc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (!qctl.empty),
      .q_data        (pop_data),
      .q_pop         (qctl.pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_type_code (rsp_type_code)
   );

   // no push into a full queue, no pop from an empty one
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      qctl.push |-> !qctl.full)
      else $error("base queue overflow");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      qctl.pop |-> !qctl.empty)
      else $error("base queue underflow");

   // a fresh code only ever follows a pop
   a_code_from_pop : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(qctl.pop))
      else $error("code without a queued base");

   a_code_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_type_code <= CODE_MAX))
      else $error("type code out of range");

endmodule

// File: bench/mime_type_classifier_tb.sv
// Self-checking testbench for the media type classifier top level.
`timescale 1ns / 100ps

module tb;
   import mtc_pkg::*;

   // Stored base length used by the block instance below.
   localparam int NAME_MAX = 32;

   // Row code meaning "take the expected code from the predictor".
   localparam int PREDICT = -1;

   // A run of this many cycles without any word moving on either side is a hang.
   // The slowest correct stretch, a sender gap plus a result stall plus the
   // latency of the block, is far shorter than this.
   localparam int QUIET_LIMIT = 2000;

   localparam int RANDOM_WORDS = 950;

   localparam char_type SPACE = 8'h20;
   localparam char_type TAB   = 8'h09;
   localparam char_type SEMI  = 8'h3b;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic                req_has_char  = 1'b0;
   logic [7:0]          req_in_char   = 8'h00;
   logic                req_last      = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [CODE_W-1:0]   rsp_type_code;

   mime_type_classifier_top #(
      .MAX_LEN(NAME_MAX)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_has_char  (req_has_char),
      .req_in_char   (req_in_char),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_type_code (rsp_type_code)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: the base as the block should hold it, and its classifier.
   // ------------------------------------------------------------------

   // The 39 listed types; code is CODE_TABLE_BASE plus the index.
   string known_types [39] = '{
      "text/*", "text/calendar", "text/css", "text/csv", "text/html",
      "text/javascript", "text/plain",
      "image/*", "image/avif", "image/bmp", "image/gif", "image/jpeg",
      "image/png", "image/svg+xml", "image/tiff", "image/webp",
      "audio/*", "audio/mpeg", "audio/ogg", "audio/opus", "audio/wav",
      "audio/webm",
      "video/*", "video/mp4", "video/mpeg", "video/ogg", "video/webm",
      "video/x-msvideo",
      "font/*", "font/ttf", "font/woff", "font/woff2",
      "application/*", "application/json", "application/octet-stream",
      "application/pdf", "application/xml", "application/x-tar",
      "application/zip"
   };

   char_type base_chars [NAME_MAX];
   int       base_fill      = 0;   // bytes held, saturates at NAME_MAX
   int       base_len       = 0;   // length without trailing blanks, NAME_MAX+1 = too long
   bit       past_semicolon = 1'b0;

   // Held base from offset off is exactly t.
   function automatic bit tail_is(int off, string t);
      if (off > base_len || base_len - off != t.len())
         return 1'b0;
      for (int i = 0; i < t.len(); i++)
         if (base_chars[off + i] != char_type'(t[i]))
            return 1'b0;
      return 1'b1;
   endfunction

   // Held base from offset off begins with t.
   function automatic bit tail_begins(int off, string t);
      if (off > base_len || base_len - off < t.len())
         return 1'b0;
      for (int i = 0; i < t.len(); i++)
         if (base_chars[off + i] != char_type'(t[i]))
            return 1'b0;
      return 1'b1;
   endfunction

   // Takes one word; returns the code it produces, or -1 when it ends nothing.
   function automatic int fold_and_classify(logic has_char, char_type ch, logic is_last);
      char_type c;
      bit       blank;
      int       code;
      int       off;
      c = ch;
      if (has_char && !past_semicolon) begin
         if (c == SEMI) begin
            past_semicolon = 1'b1;
         end else begin
            blank = (c == SPACE || c == TAB);
            if (c >= "A" && c <= "Z")
               c = c + 8'd32;
            if (base_fill < NAME_MAX) begin
               base_chars[base_fill] = c;
               base_fill++;
               if (!blank)
                  base_len = base_fill;
            end else if (!blank) begin
               base_len = NAME_MAX + 1;
            end
         end
      end
      if (!is_last)
         return -1;

      if (base_len > NAME_MAX) begin
         code = CODE_UNKNOWN;
      end else if (base_len == 0) begin
         code = CODE_EMPTY;
      end else begin
         code = -1;
         // table entries are distinct, so at most one can match
         for (int i = 0; i < 39; i++)
            if (tail_is(0, known_types[i]))
               code = CODE_TABLE_BASE + i;
         if (code < 0) begin
            if (tail_begins(0, "text/")) begin
               code = tail_is(5, "xml") ? CODE_APP_XML : CODE_TEXT_ANY;
            end else if (tail_begins(0, "image/")) begin
               code = CODE_IMAGE_ANY;
            end else if (tail_begins(0, "audio/")) begin
               code = CODE_AUDIO_ANY;
            end else if (tail_begins(0, "video/")) begin
               code = CODE_VIDEO_ANY;
            end else if (tail_begins(0, "font/")) begin
               code = CODE_FONT_ANY;
            end else if (tail_begins(0, "application/")) begin
               off = tail_begins(12, "x-") ? 14 : 12;
               if (tail_is(off, "javascript"))
                  code = CODE_JAVASCRIPT;
               else if (tail_is(off, "font-ttf"))
                  code = CODE_FONT_TTF;
               else if (tail_is(off, "font-woff"))
                  code = CODE_FONT_WOFF;
               else if (tail_is(off, "font-woff2"))
                  code = CODE_FONT_WOFF2;
               else
                  code = CODE_APP_ANY;
            end else begin
               code = CODE_UNKNOWN;
            end
         end
      end
      base_fill      = 0;
      base_len       = 0;
      past_semicolon = 1'b0;
      return code;
   endfunction

   // ------------------------------------------------------------------
   // Sender: bursts of words with random gaps between them.
   // ------------------------------------------------------------------

   logic [CODE_W-1:0] pending_codes [$];   // codes still owed by the block, oldest first
   char_type          text_q [$];          // string about to be sent
   int                burst_left    = 0;
   int                counted_words = 0;   // words sent so far
   int                failures      = 0;

   task automatic push_str(string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(char_type'(s[i]));
   endtask

   // Drives one word and holds it until taken. The owed code is queued at
   // drive time, before the block can answer it.
   task automatic send_word(logic has_char, char_type ch, logic is_last, int typed_code);
      int code;
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      counted_words++;
      code = fold_and_classify(has_char, ch, is_last);
      if (code >= 0)
         pending_codes.push_back(typed_code >= 0 ? CODE_W'(typed_code) : CODE_W'(code));
      req_valid    <= 1'b1;
      req_has_char <= has_char;
      req_in_char  <= ch;
      req_last     <= is_last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Sends text_q as one string. end_alone closes it with a char-less word;
   // sprinkle slips char-less words with junk bytes in between characters.
   task automatic send_text(bit end_alone, bit sprinkle, int typed_code);
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) begin
         if (sprinkle && $urandom_range(0, 5) == 0)
            send_word(1'b0, char_type'($urandom), 1'b0, PREDICT);
         send_word(1'b1, text_q[i], !end_alone && i == n - 1, typed_code);
      end
      if (end_alone || n == 0)
         send_word(1'b0, char_type'($urandom), 1'b1, typed_code);
   endtask

   // ------------------------------------------------------------------
   // Receiver: stall pattern picks a new random mode at regular points.
   // Modes: never, light random, heavy random, square wave.
   // A stall is cut short once stall_run reaches its limit.
   // ------------------------------------------------------------------

   int stall_mode = 0;
   int stall_tick = 0;
   int stall_run  = 0;

   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            2: hold = ($urandom_range(0, 3) != 0);
            default: hold = stall_tick[2];
         endcase
         if (stall_run >= 8)
            hold = 1'b0;
         rsp_stall <= hold;
         stall_run <= hold ? stall_run + 1 : 0;
      end
   end

   // ------------------------------------------------------------------
   // Result check: every taken code against the oldest owed one.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_codes.size() == 0) begin
            $error("type_code: expected none, got %0d", rsp_type_code);
            failures++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_type_code !== want) begin
               $error("type_code: expected %0d, got %0d", want, rsp_type_code);
               failures++;
            end
         end
      end
   end

   // Watchdog: cycles in which no word moves on either side.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Directed strings. Codes are typed in where they are plain from the
   // rules; the rest go through the predictor.
   // ------------------------------------------------------------------

   typedef struct {
      string text;
      bit    end_alone;
      bit    sprinkle;
      int    code;
   } probe_row;

   probe_row probes [24] = '{
      '{"",                                       1'b1, 1'b0, CODE_EMPTY},
      '{"text/html",                              1'b0, 1'b1, PREDICT},
      '{"TEXT/XML",                               1'b0, 1'b0, CODE_APP_XML},
      '{"text/foo",                               1'b0, 1'b0, CODE_TEXT_ANY},
      '{"image/x-icon",                           1'b0, 1'b0, CODE_IMAGE_ANY},
      '{"Audio/AAC",                              1'b0, 1'b0, CODE_AUDIO_ANY},
      '{"video/quicktime",                        1'b1, 1'b0, CODE_VIDEO_ANY},
      '{"font/otf",                               1'b0, 1'b0, CODE_FONT_ANY},
      '{"application/x-javascript",               1'b0, 1'b0, CODE_JAVASCRIPT},
      '{"application/font-ttf",                   1'b0, 1'b0, CODE_FONT_TTF},
      '{"application/x-font-woff",                1'b0, 1'b0, CODE_FONT_WOFF},
      '{"application/font-woff2",                 1'b0, 1'b0, CODE_FONT_WOFF2},
      '{"application/x-foo",                      1'b0, 1'b0, CODE_APP_ANY},
      '{"application/zip",                        1'b0, 1'b0, CODE_MAX},
      '{"Text/Plain; charset=utf-8",              1'b0, 1'b0, PREDICT},
      '{"image/png \t ",                          1'b0, 1'b0, PREDICT},
      // exactly NAME_MAX characters, then one over, then blanks past the end
      '{"application/vnd.example-abcdefgh",       1'b0, 1'b0, PREDICT},
      '{"application/vnd.example-abcdefghi",      1'b0, 1'b0, CODE_UNKNOWN},
      '{"application/vnd.example-abcdefgh \t  ",  1'b1, 1'b0, PREDICT},
      '{" \t ",                                   1'b0, 1'b0, PREDICT},
      '{";text/html",                             1'b0, 1'b0, PREDICT},
      '{"tex",                                    1'b0, 1'b1, CODE_UNKNOWN},
      '{"image/p\351g",                           1'b0, 1'b0, PREDICT},
      '{"application/octet-stream",               1'b1, 1'b1, PREDICT}
   };

   string category  [5] = '{"text/", "image/", "audio/", "video/", "font/"};
   string app_tails [8] = '{"javascript", "font-ttf", "font-woff", "font-woff2",
                            "json", "font-woff2x", "javascrip", "zip"};
   string sub_chars = "abcdefghijklmnopqrstuvwxyz0123456789-+.";

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------

   initial begin
      bit alone;
      bit sprinkle;
      int kind;
      int pick;
      int target;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[r]) begin
         text_q.delete();
         push_str(probes[r].text);
         send_text(probes[r].end_alone, probes[r].sprinkle, probes[r].code);
      end

      // Random strings: mostly well-formed types with random case, blanks and
      // parameters, plus over-long bases, blank-only strings and raw byte noise.
      while (counted_words < RANDOM_WORDS) begin
         text_q.delete();
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            push_str(known_types[$urandom_range(0, 38)]);
         end else if (kind < 55) begin
            pick = $urandom_range(0, 4);
            push_str(category[pick]);
            if (pick == 0 && $urandom_range(0, 3) == 0)
               push_str("xml");
            else
               repeat ($urandom_range(0, 10))
                  text_q.push_back(char_type'(sub_chars[$urandom_range(0, sub_chars.len() - 1)]));
         end else if (kind < 70) begin
            push_str("application/");
            if ($urandom_range(0, 1))
               push_str("x-");
            push_str(app_tails[$urandom_range(0, 7)]);
         end else if (kind < 78) begin
            // straddle the length limit
            push_str(known_types[$urandom_range(0, 38)]);
            target = $urandom_range(29, 40);
            while (text_q.size() < target)
               text_q.push_back(char_type'(sub_chars[$urandom_range(0, sub_chars.len() - 1)]));
         end else if (kind < 84) begin
            repeat ($urandom_range(0, 3))
               text_q.push_back($urandom_range(0, 1) ? SPACE : TAB);
         end else begin
            repeat ($urandom_range(0, 12))
               text_q.push_back(($urandom_range(0, 5) == 0) ? SEMI : char_type'($urandom));
         end

         if (kind < 78) begin
            foreach (text_q[i])
               if (text_q[i] >= "a" && text_q[i] <= "z" && $urandom_range(0, 3) == 0)
                  text_q[i] = text_q[i] - 8'd32;
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3))
                  text_q.push_back($urandom_range(0, 1) ? SPACE : TAB);
            if ($urandom_range(0, 4) == 0)
               push_str("; charset=UTF-8");
         end

         alone    = ($urandom_range(0, 3) == 0);
         sprinkle = ($urandom_range(0, 4) == 0);
         send_text(alone, sprinkle, PREDICT);
      end
      req_valid <= 1'b0;

      // drain, then give a stray extra code time to show up
      while (pending_codes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hdl/mtc_pkg.sv
hdl/mtc_front.sv
hdl/mtc_queue.sv
hdl/mtc_classify.sv
hdl/mime_type_classifier_top.sv
bench/mime_type_classifier_tb.sv
